// ===== rtl/locl_pkg.sv =====
// shared constants, types and register map of the loose octree cell locator
package locl_pkg;

  // tree and field geometry
  localparam int MAX_LEVELS = 8;
  localparam int COORD_W    = 32;
  localparam int SIZE_W     = 31;
  localparam int TWO_W      = SIZE_W + 1;
  localparam int DEPTH_W    = 4;
  localparam int LEVEL_W    = 4;
  localparam int LVL_W      = $clog2(MAX_LEVELS + 2);
  localparam int CELL_W     = 8;
  localparam int PATH_W     = 24;
  localparam int ALU_W      = COORD_W + 3;

  // configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_CUBE_LOW  = 2'd0;
  localparam logic [1:0] REG_CUBE_SIZE = 2'd1;
  localparam logic [1:0] REG_MAX_DEPTH = 2'd2;

  localparam logic [COORD_W-1:0] CUBE_LOW_RST  = '0;
  localparam logic [SIZE_W-1:0]  CUBE_SIZE_RST = SIZE_W'(65536);
  localparam logic [DEPTH_W-1:0] MAX_DEPTH_RST = DEPTH_W'(8);

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXT_DIFF,
    ST_EXT_CMP,
    ST_SEARCH,
    ST_SUM,
    ST_OFFS,
    ST_RANGE,
    ST_DIV,
    ST_DONE
  } locl_state_e;

  // request to the shared add/subtract unit
  typedef struct packed {
    logic                    sub;
    logic signed [ALU_W-1:0] a;
    logic signed [ALU_W-1:0] b;
  } locl_alu_req_t;

endpackage

// ===== rtl/locl_box_if.sv =====
// input channel: one axis-aligned box per item
interface locl_box_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  box_low_x;
  logic signed [31:0]  box_low_y;
  logic signed [31:0]  box_low_z;
  logic signed [31:0]  box_high_x;
  logic signed [31:0]  box_high_y;
  logic signed [31:0]  box_high_z;

  modport source (
    output valid, box_low_x, box_low_y, box_low_z, box_high_x, box_high_y, box_high_z,
    input  ready
  );
  modport sink (
    input  valid, box_low_x, box_low_y, box_low_z, box_high_x, box_high_y, box_high_z,
    output ready
  );
endinterface

// ===== rtl/locl_cell_if.sv =====
// output channel: chosen octree node per item
interface locl_cell_if;
  logic        valid;
  logic        ready;
  logic [3:0]  level;
  logic [7:0]  cell_x;
  logic [7:0]  cell_y;
  logic [7:0]  cell_z;
  logic [23:0] path_code;
  logic        out_of_cube;

  modport source (
    output valid, level, cell_x, cell_y, cell_z, path_code, out_of_cube,
    input  ready
  );
  modport sink (
    input  valid, level, cell_x, cell_y, cell_z, path_code, out_of_cube,
    output ready
  );
endinterface

// ===== rtl/locl_addsub.sv =====
// shared add/subtract unit used by every step of the sequencer
module locl_addsub (
  input  locl_pkg::locl_alu_req_t          req_i,
  output logic signed [locl_pkg::ALU_W-1:0] res_o
);
  import locl_pkg::*;

  // one wide adder, b inverted for subtraction
  always_comb begin
    if (req_i.sub) begin
      res_o = req_i.a - req_i.b;
    end else begin
      res_o = req_i.a + req_i.b;
    end
  end

endmodule

// ===== rtl/loose_octree_cell_locator.sv =====
// Loose octree cell locator: takes one box per item and returns its node level, cell
// indices, child path and an out-of-cube flag. All arithmetic runs through a single
// 35-bit add/subtract unit under a sequencer, so the block takes one item at a time:
// it finds the largest extent, runs the halving search, then per axis forms the center,
// its offset into the cube and a range check, plus one quotient bit per level when the
// center lies inside the cube, before it hands the result over. A finished result sits
// in an output register, so the next box is taken while it waits.
module loose_octree_cell_locator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  locl_box_if.sink                      box_i,
  locl_cell_if.source                   cell_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [locl_pkg::ADDR_W-1:0]   paddr,
  input  logic [locl_pkg::DATA_W-1:0]   pwdata,
  output logic [locl_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import locl_pkg::*;

  // configuration registers
  logic signed [COORD_W-1:0] cube_low_q;
  logic [SIZE_W-1:0]         cube_size_q;
  logic [DEPTH_W-1:0]        max_depth_q;
  logic                      cfg_wr;

  // sequencer and datapath registers
  locl_state_e               state_q, state_d;
  logic [1:0]                ax_q, ax_d;
  logic signed [COORD_W-1:0] lo_q [3];
  logic signed [COORD_W-1:0] hi_q [3];
  logic signed [ALU_W-1:0]   acc_q, acc_d;
  logic signed [ALU_W-1:0]   ext_q, ext_d;
  logic [TWO_W-1:0]          sh_q, sh_d;
  logic [TWO_W-1:0]          rem_q, rem_d;
  logic [LVL_W-1:0]          d_q, d_d;
  logic [LVL_W-1:0]          level_q, level_d;
  logic [LVL_W-1:0]          cnt_q, cnt_d;
  logic [MAX_LEVELS-1:0]     quo_q, quo_d;
  logic [MAX_LEVELS-1:0]     cell_q [3];
  logic [MAX_LEVELS-1:0]     cell_wr_val;
  logic                      cell_wr;
  logic                      flag_q, flag_d;

  // output register
  logic                      out_valid_q, out_valid_d;
  logic                      out_load;
  logic [LEVEL_W-1:0]        level_out_q;
  logic [CELL_W-1:0]         cx_q, cy_q, cz_q;
  logic [PATH_W-1:0]         path_q;
  logic                      oflag_q;

  // shared unit
  locl_alu_req_t             alu_req;
  logic signed [ALU_W-1:0]   alu_res;
  logic                      alu_neg;

  // derived values
  logic [SIZE_W-1:0]         size_eff;
  logic [TWO_W-1:0]          two_s;
  logic signed [ALU_W-1:0]   two_s_x;
  logic signed [ALU_W-1:0]   lo_x, hi_x, cl2_x;
  logic [TWO_W:0]            rem2;
  logic                      fits;
  logic                      in_acc;
  logic [LVL_W-1:0]          d_fin, depth_fin;
  logic [MAX_LEVELS-1:0]     top_cell;
  logic                      div_last;
  logic                      div_bit;
  logic [3*MAX_LEVELS-1:0]   path_full;

  // apb register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cube_low_q  <= CUBE_LOW_RST;
      cube_size_q <= CUBE_SIZE_RST;
      max_depth_q <= MAX_DEPTH_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_CUBE_LOW:  cube_low_q  <= pwdata[COORD_W-1:0];
        REG_CUBE_SIZE: cube_size_q <= pwdata[SIZE_W-1:0];
        REG_MAX_DEPTH: max_depth_q <= pwdata[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CUBE_LOW:  prdata = cube_low_q;
      REG_CUBE_SIZE: prdata = {{(DATA_W-SIZE_W){1'b0}}, cube_size_q};
      REG_MAX_DEPTH: prdata = {{(DATA_W-DEPTH_W){1'b0}}, max_depth_q};
      default:       prdata = '0;
    endcase
  end

  // operand preparation
  assign size_eff = (cube_size_q == '0) ? SIZE_W'(1) : cube_size_q;
  assign two_s    = {size_eff, 1'b0};
  assign two_s_x  = {{(ALU_W-TWO_W){1'b0}}, two_s};
  assign lo_x     = {{(ALU_W-COORD_W){lo_q[ax_q][COORD_W-1]}}, lo_q[ax_q]};
  assign hi_x     = {{(ALU_W-COORD_W){hi_q[ax_q][COORD_W-1]}}, hi_q[ax_q]};
  assign cl2_x    = {{(ALU_W-COORD_W-1){cube_low_q[COORD_W-1]}}, cube_low_q, 1'b0};
  assign rem2     = {rem_q, 1'b0};
  assign in_acc   = box_i.valid && box_i.ready;
  assign top_cell = ~({MAX_LEVELS{1'b1}} << level_q);

  // shared unit operand select
  always_comb begin
    alu_req = '{sub: 1'b1, a: '0, b: '0};
    unique case (state_q)
      ST_EXT_DIFF: alu_req = '{sub: 1'b1, a: hi_x, b: lo_x};
      ST_EXT_CMP:  alu_req = '{sub: 1'b1, a: ext_q, b: acc_q};
      ST_SEARCH:   alu_req = '{sub: 1'b1, a: {{(ALU_W-TWO_W){1'b0}}, sh_q}, b: ext_q};
      ST_SUM:      alu_req = '{sub: 1'b0, a: lo_x, b: hi_x};
      ST_OFFS:     alu_req = '{sub: 1'b1, a: acc_q, b: cl2_x};
      ST_RANGE:    alu_req = '{sub: 1'b1, a: acc_q, b: two_s_x};
      ST_DIV:      alu_req = '{sub: 1'b1, a: {{(ALU_W-TWO_W-1){1'b0}}, rem2}, b: two_s_x};
      default:     alu_req = '{sub: 1'b1, a: '0, b: '0};
    endcase
  end

  locl_addsub u_addsub (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  assign alu_neg = alu_res[ALU_W-1];

  // halving search step and depth
  assign fits      = (ext_q <= 0) || !alu_neg;
  assign d_fin     = fits ? d_q + LVL_W'(1) : d_q;
  assign depth_fin = (d_fin == '0) ? '0 : d_fin - LVL_W'(1);
  assign div_last  = (cnt_q == level_q - LVL_W'(1));
  assign div_bit   = !alu_neg;
  assign out_load  = (state_q == ST_DONE) && (!out_valid_q || cell_o.ready);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_acc) state_d = ST_EXT_DIFF;
      ST_EXT_DIFF: state_d = ST_EXT_CMP;
      ST_EXT_CMP:  state_d = (ax_q == 2'd2) ? ST_SEARCH : ST_EXT_DIFF;
      ST_SEARCH: begin
        if (!fits || d_q == LVL_W'(MAX_LEVELS)) state_d = ST_SUM;
      end
      ST_SUM:      state_d = ST_OFFS;
      ST_OFFS:     state_d = ST_RANGE;
      ST_RANGE: begin
        if (acc_q >= 0 && alu_neg && level_q != '0) begin
          state_d = ST_DIV;
        end else begin
          state_d = (ax_q == 2'd2) ? ST_DONE : ST_SUM;
        end
      end
      ST_DIV: begin
        if (div_last) state_d = (ax_q == 2'd2) ? ST_DONE : ST_SUM;
      end
      ST_DONE:     if (out_load) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    ax_d        = ax_q;
    acc_d       = acc_q;
    ext_d       = ext_q;
    sh_d        = sh_q;
    rem_d       = rem_q;
    d_d         = d_q;
    level_d     = level_q;
    cnt_d       = cnt_q;
    quo_d       = quo_q;
    flag_d      = flag_q;
    cell_wr     = 1'b0;
    cell_wr_val = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          ax_d   = '0;
          d_d    = '0;
          flag_d = 1'b0;
        end
      end
      ST_EXT_DIFF: acc_d = alu_res;
      ST_EXT_CMP: begin
        if (ax_q == 2'd0 || alu_neg) ext_d = acc_q;
        if (ax_q == 2'd2) begin
          ax_d = '0;
          sh_d = two_s >> 1;
        end else begin
          ax_d = ax_q + 2'd1;
        end
      end
      ST_SEARCH: begin
        d_d  = d_fin;
        sh_d = sh_q >> 1;
        if (depth_fin > LVL_W'(max_depth_q) && max_depth_q < DEPTH_W'(MAX_LEVELS + 1)) begin
          level_d = LVL_W'(max_depth_q);
        end else begin
          level_d = depth_fin;
        end
      end
      ST_SUM:  acc_d = alu_res;
      ST_OFFS: acc_d = alu_res;
      ST_RANGE: begin
        cnt_d = '0;
        quo_d = '0;
        rem_d = acc_q[TWO_W-1:0];
        if (acc_q < 0) begin
          // center below the cube
          flag_d  = 1'b1;
          cell_wr = 1'b1;
        end else if (!alu_neg) begin
          // center on or above the high face
          if (alu_res != 0) flag_d = 1'b1;
          cell_wr     = 1'b1;
          cell_wr_val = top_cell;
        end else if (level_q == '0) begin
          cell_wr = 1'b1;
        end
        if (cell_wr) ax_d = ax_q + 2'd1;
      end
      ST_DIV: begin
        // one restoring quotient bit per cycle
        quo_d = (quo_q << 1) | {{(MAX_LEVELS-1){1'b0}}, div_bit};
        rem_d = div_bit ? alu_res[TWO_W-1:0] : rem2[TWO_W-1:0];
        cnt_d = cnt_q + LVL_W'(1);
        if (div_last) begin
          cell_wr     = 1'b1;
          cell_wr_val = quo_d;
          ax_d        = ax_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ax_q        <= '0;
      d_q         <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ax_q        <= ax_d;
      d_q         <= d_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    ext_q   <= ext_d;
    sh_q    <= sh_d;
    rem_q   <= rem_d;
    level_q <= level_d;
    quo_q   <= quo_d;
    flag_q  <= flag_d;
    if (in_acc) begin
      lo_q[0] <= box_i.box_low_x;
      lo_q[1] <= box_i.box_low_y;
      lo_q[2] <= box_i.box_low_z;
      hi_q[0] <= box_i.box_high_x;
      hi_q[1] <= box_i.box_high_y;
      hi_q[2] <= box_i.box_high_z;
    end
    if (cell_wr) cell_q[ax_q] <= cell_wr_val;
  end

  // child path: interleave cell bits, first level ends up most significant
  always_comb begin
    for (int i = 0; i < MAX_LEVELS; i++) begin
      path_full[3*i]     = cell_q[0][i];
      path_full[3*i + 1] = cell_q[1][i];
      path_full[3*i + 2] = cell_q[2][i];
    end
  end

  // output register
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (cell_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      level_out_q <= LEVEL_W'(level_q);
      cx_q        <= CELL_W'(cell_q[0]);
      cy_q        <= CELL_W'(cell_q[1]);
      cz_q        <= CELL_W'(cell_q[2]);
      path_q      <= PATH_W'(path_full);
      oflag_q     <= flag_q;
    end
  end

  assign box_i.ready        = (state_q == ST_IDLE);
  assign cell_o.valid       = out_valid_q;
  assign cell_o.level       = level_out_q;
  assign cell_o.cell_x      = cx_q;
  assign cell_o.cell_y      = cy_q;
  assign cell_o.cell_z      = cz_q;
  assign cell_o.path_code   = path_q;
  assign cell_o.out_of_cube = oflag_q;

  // checks
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_EXT_DIFF)
    else $error("accepted item did not start the extent pass");

  a_search_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEARCH |-> d_q <= LVL_W'(MAX_LEVELS))
    else $error("halving search ran past the level limit");

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> cnt_q < level_q && level_q <= LVL_W'(MAX_LEVELS))
    else $error("division ran past the chosen level");

  a_cell_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |-> ((cell_q[0] >> level_q) == '0) &&
                           ((cell_q[1] >> level_q) == '0) &&
                           ((cell_q[2] >> level_q) == '0))
    else $error("cell index exceeds the node count of its level");

endmodule
